// ===== sv/pfe_pkg.sv =====
// ---------------------------------------------------------------------------
// Postfix expression evaluator package
// Shared types, character codes, status codes and the command and status
// structs that join the controller and the datapath.
// ---------------------------------------------------------------------------
package pfe_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned SYM_W  = 8;

  localparam logic [SYM_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [SYM_W-1:0] CH_NINE  = 8'h39;
  localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] CH_MUL   = 8'h2A;
  localparam logic [SYM_W-1:0] CH_DIV   = 8'h2F;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNDERFLOW = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_DIVZERO   = 3'd3,
    ST_BADSYM    = 3'd4,
    ST_SIZE      = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_EXEC,
    S_DIV,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic    load_in;
    logic    push;
    logic    read_nos;
    logic    arith;
    logic    div_start;
    logic    div_commit;
    logic    set_err;
    status_t err_code;
    logic    finish;
  } dp_cmd_t;

  typedef struct packed {
    logic is_digit;
    logic is_op;
    logic is_div;
    logic full;
    logic lt2;
    logic rhs_zero;
    logic err_set;
    logic last;
    logic div_done;
  } dp_sts_t;

endpackage

// ===== sv/pfe_div.sv =====
// ---------------------------------------------------------------------------
// Iterative signed divider
// Restoring division of magnitudes, one quotient bit per cycle, with the
// sign applied at the end. The quotient truncates toward zero.
// ---------------------------------------------------------------------------
module pfe_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [pfe_pkg::DATA_W-1:0] dividend,
  input  logic [pfe_pkg::DATA_W-1:0] divisor,
  output logic                       done,
  output logic [pfe_pkg::DATA_W-1:0] quotient
);
  import pfe_pkg::*;

  localparam int unsigned CNT_W = $clog2(DATA_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] quo_r, quo_nxt;
  logic [DATA_W-1:0] dvs_r, dvs_nxt;
  logic              neg_r, neg_nxt;
  logic [DATA_W-1:0] rem_sh;
  logic [DATA_W-1:0] abs_a, abs_b;

  assign abs_a = dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
  assign abs_b = divisor[DATA_W-1]  ? (DATA_W'(0) - divisor)  : divisor;
  assign rem_sh = {rem_r[DATA_W-2:0], quo_r[DATA_W-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DATA_W);
      rem_nxt  = '0;
      quo_nxt  = abs_a;
      dvs_nxt  = abs_b;
      neg_nxt  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
    end else if (busy_r) begin
      // The dividend shifts out of the top of the quotient register while
      // quotient bits shift in at the bottom.
      if (rem_sh >= dvs_r) begin
        rem_nxt = rem_sh - dvs_r;
        quo_nxt = {quo_r[DATA_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        quo_nxt = {quo_r[DATA_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? (DATA_W'(0) - quo_r) : quo_r;

endmodule

// ===== sv/pfe_dpath.sv =====
// ---------------------------------------------------------------------------
// Postfix evaluator datapath
// Operand stack (top entry in a register, the rest in a memory), arithmetic
// unit, divider, sticky error register and the result registers.
// ---------------------------------------------------------------------------
module pfe_dpath #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [pfe_pkg::SYM_W-1:0]  in_symbol,
  input  logic                       in_last,
  input  pfe_pkg::dp_cmd_t           cmd,
  output pfe_pkg::dp_sts_t           sts,
  output logic [pfe_pkg::DATA_W-1:0] out_result_value,
  output logic [2:0]                 out_status
);
  import pfe_pkg::*;

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  logic [DATA_W-1:0] mem [STACK_DEPTH];
  logic [DATA_W-1:0] nos_r;
  logic [DATA_W-1:0] top_r, top_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  status_t           err_r, err_nxt;
  logic [SYM_W-1:0]  sym_r;
  logic              last_r;
  logic [DATA_W-1:0] res_r;
  status_t           stat_r;

  logic [CW-1:0]     cnt_m1, cnt_m2;
  logic [DATA_W-1:0] digit_val;
  logic [DATA_W-1:0] arith_res;
  logic [DATA_W-1:0] div_q;
  logic              div_done;
  status_t           fin_stat;

  assign cnt_m1    = count_r - CW'(1);
  assign cnt_m2    = count_r - CW'(2);
  assign digit_val = {{(DATA_W-SYM_W){1'b0}}, sym_r - CH_ZERO};

  pfe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (nos_r),
    .divisor  (top_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    case (sym_r)
      CH_PLUS:  arith_res = nos_r + top_r;
      CH_MINUS: arith_res = nos_r - top_r;
      default:  arith_res = nos_r * top_r;
    endcase
  end

  always_comb begin
    if (err_r != ST_OK) begin
      fin_stat = err_r;
    end else if (count_r == CW'(1)) begin
      fin_stat = ST_OK;
    end else begin
      fin_stat = ST_SIZE;
    end
  end

  always_comb begin
    top_nxt   = top_r;
    count_nxt = count_r;
    err_nxt   = err_r;
    if (cmd.push) begin
      top_nxt   = digit_val;
      count_nxt = count_r + CW'(1);
    end
    if (cmd.arith) begin
      top_nxt   = arith_res;
      count_nxt = cnt_m1;
    end
    if (cmd.div_commit) begin
      top_nxt   = div_q;
      count_nxt = cnt_m1;
    end
    if (cmd.set_err) begin
      err_nxt = cmd.err_code;
    end
    if (cmd.finish) begin
      count_nxt = '0;
      err_nxt   = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      err_r   <= ST_OK;
    end else begin
      count_r <= count_nxt;
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    if (cmd.load_in) begin
      sym_r  <= in_symbol;
      last_r <= in_last;
    end
    if (cmd.finish) begin
      stat_r <= fin_stat;
      res_r  <= (fin_stat == ST_OK) ? top_r : '0;
    end
  end

  // The register holds the top entry, so a push moves the old top into
  // the memory, one place below the old count.
  always_ff @(posedge clk) begin
    if (cmd.push && (count_r != '0)) begin
      mem[cnt_m1[AW-1:0]] <= top_r;
    end
    if (cmd.read_nos) begin
      nos_r <= mem[cnt_m2[AW-1:0]];
    end
  end

  always_comb begin
    sts.is_digit = (sym_r >= CH_ZERO) && (sym_r <= CH_NINE);
    sts.is_op    = (sym_r == CH_PLUS) || (sym_r == CH_MINUS) ||
                   (sym_r == CH_MUL)  || (sym_r == CH_DIV);
    sts.is_div   = (sym_r == CH_DIV);
    sts.full     = (count_r >= CW'(STACK_DEPTH));
    sts.lt2      = (count_r < CW'(2));
    sts.rhs_zero = (top_r == '0);
    sts.err_set  = (err_r != ST_OK);
    sts.last     = last_r;
    sts.div_done = div_done;
  end

  assign out_result_value = res_r;
  assign out_status       = stat_r;

endmodule

// ===== sv/pfe_ctrl.sv =====
// ---------------------------------------------------------------------------
// Postfix evaluator controller
// Sequences one item at a time through decode, execute, divide and finish, and owns
// the handshakes of both channels.
// ---------------------------------------------------------------------------
module pfe_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  pfe_pkg::dp_sts_t sts,
  output pfe_pkg::dp_cmd_t cmd
);
  import pfe_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.err_code = ST_OK;
    in_ready     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_FINISH;
        // After an error the rest of the expression only waits for its end.
        if (!sts.err_set) begin
          if (sts.is_digit) begin
            if (sts.full) begin
              cmd.set_err  = 1'b1;
              cmd.err_code = ST_OVERFLOW;
            end else begin
              cmd.push = 1'b1;
            end
          end else if (!sts.is_op) begin
            cmd.set_err  = 1'b1;
            cmd.err_code = ST_BADSYM;
          end else if (sts.lt2) begin
            cmd.set_err  = 1'b1;
            cmd.err_code = ST_UNDERFLOW;
          end else begin
            cmd.read_nos = 1'b1;
            state_nxt    = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        state_nxt = S_FINISH;
        if (sts.is_div) begin
          if (sts.rhs_zero) begin
            cmd.set_err  = 1'b1;
            cmd.err_code = ST_DIVZERO;
          end else begin
            cmd.div_start = 1'b1;
            state_nxt     = S_DIV;
          end
        end else begin
          cmd.arith = 1'b1;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.div_commit = 1'b1;
          state_nxt      = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!sts.last) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== sv/postfix_expression_evaluator.sv =====
// ---------------------------------------------------------------------------
// Postfix expression evaluator
// Evaluates a reverse Polish expression of single digits and + - * /, one
// character per item, with one result item at the end of each expression.
// ---------------------------------------------------------------------------
// One item is handled at a time. A digit, a bad character, an underflow, an
// overflow or an item that follows an error passes through decode and
// finish; an add, subtract or multiply, and a divide by zero, also pass
// through execute; a divide also waits in the divide state for the
// bit-serial divider. The final item of an expression loads the result
// register and is held back only while an earlier result has not yet been
// taken. Results hold 0 in the value field whenever the status is not ok,
// and the stack starts empty for every expression. The operand stack lives
// in a memory of STACK_DEPTH entries with its top entry in a register; it
// needs no clearing after reset.
module postfix_expression_evaluator #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [pfe_pkg::SYM_W-1:0]  in_symbol,
  input  logic                       in_last,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [pfe_pkg::DATA_W-1:0] out_result_value,
  output logic [2:0]                 out_status
);
  import pfe_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  pfe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pfe_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_symbol        (in_symbol),
    .in_last          (in_last),
    .cmd              (cmd),
    .sts              (sts),
    .out_result_value (out_result_value),
    .out_status       (out_status)
  );

  // An accepted item keeps the input closed while it is worked on.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted again straight after an item");

  // A push is never issued against a full stack.
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> !sts.full)
    else $error("push issued with the stack full");

  // A new result appears only where the controller finished an expression.
  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.finish))
    else $error("result appeared without a finished expression");

  // A failed expression always reports a zero value.
  a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> (out_result_value == '0))
    else $error("non-zero value reported with an error status");

endmodule

// ===== bench/testbench.sv =====
// ---------------------------------------------------------------------------
// Postfix expression evaluator testbench
// Drives character items through the valid/ready input, predicts each
// expression's result with a behavioural stack calculator and checks every
// result item field by field. A short table of hand-picked expressions comes
// first, then random expressions in phases of sender and receiver idling.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pfe_pkg::*;

  localparam int unsigned HALF_PERIOD   = 5;
  localparam int unsigned CAPACITY      = 16;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned RANDOM_ITEMS  = 450;
  localparam int unsigned SETTLE_CYCLES = 50;
  localparam int unsigned REPORT_LIMIT  = 10;

  typedef struct {
    logic [DATA_W-1:0] value;
    status_t           status;
  } result_t;

  typedef struct {
    logic [SYM_W-1:0]  sym;
    logic              lst;
    bit                typed;
    logic [DATA_W-1:0] value;
    status_t           status;
  } plan_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [SYM_W-1:0]  in_symbol = '0;
  logic              in_last = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [DATA_W-1:0] out_result_value;
  logic [2:0]        out_status;

  // Expected result carried alongside the item for rows whose answer is typed in.
  bit      row_typed = 1'b0;
  result_t row_expect;

  // Calculator state mirrored from the block.
  logic [DATA_W-1:0] operand_stack [CAPACITY];
  int unsigned       operand_count = 0;
  status_t           sticky_status = ST_OK;
  result_t           awaited_results [$];

  int unsigned mismatch_count = 0;
  int unsigned live_items = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_ack = 0;
  int unsigned hold_left = 0;

  plan_row_t directed_plan [26] = '{
    '{CH_ZERO + 8'd5, 1'b1, 1'b1, 32'd5,      ST_OK},
    '{CH_ZERO + 8'd9, 1'b0, 1'b0, '0,         ST_OK},
    '{CH_ZERO + 8'd9, 1'b0, 1'b0, '0,         ST_OK},
    '{CH_MUL,         1'b0, 1'b0, '0,         ST_OK},
    '{CH_ZERO + 8'd4, 1'b0, 1'b0, '0,         ST_OK},
    '{CH_PLUS,        1'b1, 1'b1, 32'd85,     ST_OK},
    '{CH_ZERO,        1'b0, 1'b0, '0,         ST_OK},
    '{CH_ZERO + 8'd9, 1'b0, 1'b0, '0,         ST_OK},
    '{CH_MINUS,       1'b1, 1'b1, -32'sd9,    ST_OK},
    '{CH_ZERO + 8'd7, 1'b0, 1'b0, '0,         ST_OK},
    '{CH_ZERO,        1'b0, 1'b0, '0,         ST_OK},
    '{CH_ZERO + 8'd2, 1'b0, 1'b0, '0,         ST_OK},
    '{CH_MINUS,       1'b0, 1'b0, '0,         ST_OK},
    '{CH_DIV,         1'b1, 1'b0, '0,         ST_OK},
    '{CH_ZERO + 8'd3, 1'b0, 1'b0, '0,         ST_OK},
    '{CH_ZERO,        1'b0, 1'b0, '0,         ST_OK},
    '{CH_DIV,         1'b1, 1'b1, '0,         ST_DIVZERO},
    '{CH_PLUS,        1'b1, 1'b1, '0,         ST_UNDERFLOW},
    '{CH_ZERO + 8'd8, 1'b0, 1'b0, '0,         ST_OK},
    '{8'hFF,          1'b1, 1'b1, '0,         ST_BADSYM},
    '{CH_ZERO + 8'd1, 1'b0, 1'b0, '0,         ST_OK},
    '{CH_ZERO + 8'd2, 1'b1, 1'b1, '0,         ST_SIZE},
    '{8'h00,          1'b0, 1'b0, '0,         ST_OK},
    '{CH_ZERO + 8'd5, 1'b0, 1'b0, '0,         ST_OK},
    '{CH_ZERO + 8'd5, 1'b0, 1'b0, '0,         ST_OK},
    '{CH_PLUS,        1'b1, 1'b1, '0,         ST_BADSYM}
  };

  postfix_expression_evaluator #(
    .STACK_DEPTH(CAPACITY)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_symbol        (in_symbol),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_value (out_result_value),
    .out_status       (out_status)
  );

  always #HALF_PERIOD clk = ~clk;

  // Applies one character to the calculator; returns 1 when it ends an
  // expression, with the result that the block should then give.
  function automatic bit evaluate_symbol(input logic [SYM_W-1:0] sym, input logic lst,
                                         output result_t outcome);
    logic [DATA_W-1:0] lhs;
    logic [DATA_W-1:0] rhs;
    logic [DATA_W-1:0] folded;
    outcome.value  = '0;
    outcome.status = ST_OK;
    if (sticky_status == ST_OK) begin
      if (sym >= CH_ZERO && sym <= CH_NINE) begin
        if (operand_count >= CAPACITY) begin
          sticky_status = ST_OVERFLOW;
        end else begin
          operand_stack[operand_count] = DATA_W'(sym - CH_ZERO);
          operand_count++;
        end
      end else if (sym != CH_PLUS && sym != CH_MINUS && sym != CH_MUL && sym != CH_DIV) begin
        sticky_status = ST_BADSYM;
      end else if (operand_count < 2) begin
        sticky_status = ST_UNDERFLOW;
      end else begin
        rhs = operand_stack[operand_count-1];
        lhs = operand_stack[operand_count-2];
        folded = '0;
        case (sym)
          CH_PLUS:  folded = lhs + rhs;
          CH_MINUS: folded = lhs - rhs;
          CH_MUL:   folded = lhs * rhs;
          default: begin
            // Negation covers the minimum divided by minus one, which wraps.
            if (rhs == '1) folded = -lhs;
            else if (rhs != '0) folded = $signed(lhs) / $signed(rhs);
          end
        endcase
        if (sym == CH_DIV && rhs == '0) begin
          sticky_status = ST_DIVZERO;
        end else begin
          operand_stack[operand_count-2] = folded;
          operand_count--;
        end
      end
    end
    if (!lst) return 1'b0;
    outcome.status = sticky_status;
    if (sticky_status == ST_OK) begin
      if (operand_count == 1) outcome.value = operand_stack[0];
      else outcome.status = ST_SIZE;
    end
    operand_count = 0;
    sticky_status = ST_OK;
    return 1'b1;
  endfunction

  task automatic log_fault(input string text);
    if (mismatch_count < REPORT_LIMIT) $display("%0t: %s", $time, text);
    mismatch_count++;
  endtask

  // Results are checked before the accepted item is predicted, so a result can
  // never be matched against an expectation made at the same edge.
  always @(posedge clk) begin
    result_t want;
    result_t outcome;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          log_fault($sformatf("unexpected result: value %0d status %0d",
                              $signed(out_result_value), out_status));
        end else begin
          want = awaited_results.pop_front();
          if (out_result_value !== want.value)
            log_fault($sformatf("result_value: expected %0d, got %0d",
                                $signed(want.value), $signed(out_result_value)));
          if (out_status !== want.status)
            log_fault($sformatf("status: expected %0d, got %0d", want.status, out_status));
        end
      end
      if (in_valid && in_ready) begin
        if (sticky_status == ST_OK) live_items++;
        if (evaluate_symbol(in_symbol, in_last, outcome)) begin
          if (row_typed) awaited_results.push_back(row_expect);
          else awaited_results.push_back(outcome);
        end
      end
    end
  end

  // Result side: random stalls, plus a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_ack != hold_req) begin
      hold_ack = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic offer(input logic [SYM_W-1:0] sym, input logic lst, input bit typed,
                       input result_t want);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_symbol  <= sym;
    in_last    <= lst;
    row_typed  <= typed;
    row_expect <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_plain(input logic [SYM_W-1:0] sym, input logic lst);
    result_t unused;
    unused.value  = '0;
    unused.status = ST_OK;
    offer(sym, lst, 1'b0, unused);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (awaited_results.size() != 0) @(negedge clk);
  endtask

  function automatic logic [SYM_W-1:0] any_digit();
    return CH_ZERO + SYM_W'($urandom_range(9));
  endfunction

  function automatic logic [SYM_W-1:0] any_operator();
    case ($urandom_range(3))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_MUL;
      default: return CH_DIV;
    endcase
  endfunction

  // A well-formed expression of the given number of digits; when spoilt, one
  // item is swapped for an arbitrary byte.
  task automatic send_expression(input int unsigned leaves, input bit push_first,
                                 input bit spoil);
    int unsigned held;
    int unsigned left;
    int unsigned total;
    int unsigned spoil_at;
    logic [SYM_W-1:0] sym;
    held = 0;
    left = leaves;
    total = 2 * leaves - 1;
    spoil_at = spoil ? $urandom_range(total - 1) : total;
    for (int unsigned n = 0; n < total; n++) begin
      if (left > 0 && (held < 2 || push_first || $urandom_range(1) == 1)) begin
        sym = any_digit();
        left--;
        held++;
      end else begin
        sym = any_operator();
        held--;
      end
      if (n == spoil_at) sym = SYM_W'($urandom_range(255));
      send_plain(sym, n == total - 1);
    end
  endtask

  task automatic send_overflow();
    int unsigned pushes;
    pushes = CAPACITY + $urandom_range(1, 2);
    repeat (pushes) send_plain(any_digit(), 1'b0);
    send_plain(any_operator(), 1'b1);
  endtask

  task automatic send_noise();
    int unsigned count;
    count = $urandom_range(1, 6);
    for (int unsigned n = 0; n < count; n++)
      send_plain(SYM_W'($urandom_range(255)), n == count - 1);
  endtask

  // Builds 2**31, which wraps to the minimum, then divides it by minus one.
  task automatic send_minimum_by_minus_one();
    send_plain(CH_ZERO + 8'd8, 1'b0);
    repeat (9) begin
      send_plain(CH_ZERO + 8'd8, 1'b0);
      send_plain(CH_MUL, 1'b0);
    end
    send_plain(CH_ZERO + 8'd2, 1'b0);
    send_plain(CH_MUL, 1'b0);
    send_plain(CH_ZERO, 1'b0);
    send_plain(CH_ZERO + 8'd1, 1'b0);
    send_plain(CH_MINUS, 1'b0);
    send_plain(CH_DIV, 1'b1);
  endtask

  task automatic send_random_expression();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 60) send_expression($urandom_range(1, 6), 1'b0, 1'b0);
    else if (pick < 68) send_expression($urandom_range(10, CAPACITY), $urandom_range(1), 1'b0);
    else if (pick < 76) send_overflow();
    else if (pick < 86) send_expression($urandom_range(1, 6), 1'b0, 1'b1);
    else if (pick < 97) send_noise();
    else send_minimum_by_minus_one();
  endtask

  initial begin
    result_t want;
    int unsigned goal;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_plan[i]) begin
      want.value  = directed_plan[i].value;
      want.status = directed_plan[i].status;
      offer(directed_plan[i].sym, directed_plan[i].lst, directed_plan[i].typed, want);
    end
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct = 0;
          stall_pct <= 0;
          // The receiver holds off while items keep coming, so the input backs up.
          hold_req <= hold_req + 1;
        end
        1: begin
          idle_pct = 50;
          stall_pct <= 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct <= 50;
        end
        default: begin
          idle_pct = 14;
          stall_pct <= 14;
        end
      endcase
      goal = live_items + RANDOM_ITEMS / 4;
      if (phase == 0) send_minimum_by_minus_one();
      while (live_items < goal) send_random_expression();
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
